// ===== hdl/rne_pkg.sv =====
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, microcode table and numeral table of the Roman numeral
// encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int VALUE_W  = 12;
    localparam int LETTER_W = 8;
    localparam int PLACE_W  = 10;
    localparam int POS_W    = 3;
    localparam int COUNT_W  = 4;
    localparam int STEP_W   = 3;
    localparam int OP_W     = 3;
    localparam int BR_W     = 2;

    localparam logic [POS_W-1:0]   POS_LAST  = 3'd6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    localparam logic [LETTER_W-1:0] CHAR_M = 8'h6d;
    localparam logic [LETTER_W-1:0] CHAR_D = 8'h64;
    localparam logic [LETTER_W-1:0] CHAR_C = 8'h63;
    localparam logic [LETTER_W-1:0] CHAR_L = 8'h6c;
    localparam logic [LETTER_W-1:0] CHAR_X = 8'h78;
    localparam logic [LETTER_W-1:0] CHAR_V = 8'h76;
    localparam logic [LETTER_W-1:0] CHAR_I = 8'h69;

    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_TEST  = 3'd1;
    localparam logic [OP_W-1:0] OP_MAIN  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

    localparam logic [BR_W-1:0] BR_START = 2'd0;
    localparam logic [BR_W-1:0] BR_TEST  = 2'd1;
    localparam logic [BR_W-1:0] BR_OUT   = 2'd2;

    localparam logic [STEP_W-1:0] STEP_LOAD  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_TEST  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MAIN  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SUB   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_FLUSH = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BR_W-1:0]   br;
        logic [STEP_W-1:0] nxt;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic take_main;
        logic take_sub;
        logic finish;
        logic out_ok;
    } status_t;

    function automatic ctrl_t rne_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        case (step)
            STEP_LOAD:  w = '{op: OP_LOAD,  br: BR_START, nxt: STEP_TEST};
            STEP_TEST:  w = '{op: OP_TEST,  br: BR_TEST,  nxt: STEP_TEST};
            STEP_MAIN:  w = '{op: OP_MAIN,  br: BR_OUT,   nxt: STEP_TEST};
            STEP_SUB:   w = '{op: OP_SUB,   br: BR_OUT,   nxt: STEP_TEST};
            STEP_FLUSH: w = '{op: OP_FLUSH, br: BR_OUT,   nxt: STEP_LOAD};
            default:    w = '{op: OP_LOAD,  br: BR_START, nxt: STEP_TEST};
        endcase
        return w;
    endfunction

    function automatic logic [LETTER_W-1:0] main_letter(input logic [POS_W-1:0] pos);
        case (pos)
            3'd0:    return CHAR_M;
            3'd1:    return CHAR_D;
            3'd2:    return CHAR_C;
            3'd3:    return CHAR_L;
            3'd4:    return CHAR_X;
            3'd5:    return CHAR_V;
            default: return CHAR_I;
        endcase
    endfunction

    function automatic logic [PLACE_W-1:0] place_value(input logic [POS_W-1:0] pos);
        case (pos)
            3'd0:    return 10'd1000;
            3'd1:    return 10'd500;
            3'd2:    return 10'd100;
            3'd3:    return 10'd50;
            3'd4:    return 10'd10;
            3'd5:    return 10'd5;
            default: return 10'd1;
        endcase
    endfunction

    function automatic logic [LETTER_W-1:0] sub_letter(input logic [POS_W-1:0] pos);
        case (pos)
            3'd0, 3'd1: return CHAR_C;
            3'd2, 3'd3: return CHAR_X;
            default:    return CHAR_I;
        endcase
    endfunction

    function automatic logic [PLACE_W-1:0] sub_unit(input logic [POS_W-1:0] pos);
        case (pos)
            3'd0, 3'd1: return 10'd100;
            3'd2, 3'd3: return 10'd10;
            default:    return 10'd1;
        endcase
    endfunction

endpackage

// ===== hdl/rne_sequencer.sv =====
// ----------------------------------------------------------------------------
// rne_sequencer
// Step counter and microcode table; picks the next step from the datapath
// status and hands the current control word to the datapath.
// ----------------------------------------------------------------------------
module rne_sequencer
    import rne_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ctrl_t   ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctrl = rne_rom(step_reg);

    always_comb begin
        step_next = step_reg;
        case (ctrl.br)
            BR_START: begin
                if (status.start) step_next = ctrl.nxt;
            end
            BR_TEST: begin
                if (status.take_main) begin
                    step_next = STEP_MAIN;
                end else if (status.finish) begin
                    step_next = STEP_FLUSH;
                end else if (status.take_sub) begin
                    step_next = STEP_SUB;
                end else begin
                    step_next = ctrl.nxt;
                end
            end
            BR_OUT: begin
                if (status.out_ok) step_next = ctrl.nxt;
            end
            default: step_next = STEP_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hdl/roman_numeral_encoder.sv =====
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 12-bit unsigned number into its lower-case Roman numeral,
// one ASCII letter per output beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat carries a number in s_tdata[11:0]. s_tready is
//   high only while the block waits for a new number.
//   m_ channel: one beat per letter in m_tdata[7:0]; m_tlast marks the final
//   letter of a numeral. Zero gives no beat at all.
//   Sequence: a microcoded sequencer runs a test step and an emit step per
//   letter, plus a test step per table advance (at most six), plus a load,
//   a closing test and a flush step. A new number is taken only in the load
//   step, after the flush step of the last one.
//   Each letter is held in a pending register until the next emit or flush
//   step so that the last one can be marked; the output register decouples
//   the sequencer from m_tready. When the receiver stalls, the emit and flush
//   steps hold while a letter is pending and the output register is not free.
//   Reset clears the sequencer, the pending letter and the output register;
//   the block then waits for a number.
// ----------------------------------------------------------------------------
module roman_numeral_encoder
    import rne_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] letter
    output logic        m_tlast    // last_letter
);

    ctrl_t   ctrl;
    status_t status;

    logic [VALUE_W-1:0]  rem_reg, rem_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [LETTER_W-1:0] pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic [PLACE_W-1:0] pv;
    logic [PLACE_W-1:0] unit;
    logic [VALUE_W-1:0] pv_ext;
    logic [VALUE_W-1:0] sum;
    logic               out_free;
    logic               push;

    assign pv       = place_value(pos_reg);
    assign unit     = sub_unit(pos_reg);
    assign pv_ext   = {{(VALUE_W-PLACE_W){1'b0}}, pv};
    assign sum      = rem_reg + {{(VALUE_W-PLACE_W){1'b0}}, unit};
    assign out_free = !out_valid_reg || m_tready;

    assign status.start     = s_tvalid;
    assign status.take_main = (rem_reg >= pv_ext) && (cnt_reg != COUNT_MAX);
    assign status.finish    = (rem_reg == '0) || (cnt_reg == COUNT_MAX)
                              || (pos_reg == POS_LAST);
    assign status.take_sub  = sum >= pv_ext;
    assign status.out_ok    = !pend_valid_reg || out_free;

    rne_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    assign s_tready = (ctrl.op == OP_LOAD);

    always_comb begin
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        push            = 1'b0;
        case (ctrl.op)
            OP_LOAD: begin
                if (s_tvalid) begin
                    rem_next        = s_tdata[VALUE_W-1:0];
                    pos_next        = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            OP_TEST: begin
                if (!status.take_main && !status.finish && !status.take_sub) begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            OP_MAIN, OP_SUB: begin
                if (status.out_ok) begin
                    push            = pend_valid_reg;
                    out_last_next   = pend_valid_reg ? 1'b0 : out_last_reg;
                    pend_valid_next = 1'b1;
                    cnt_next        = cnt_reg + 4'd1;
                    if (ctrl.op == OP_MAIN) begin
                        pend_next = main_letter(pos_reg);
                        rem_next  = rem_reg - pv_ext;
                    end else begin
                        pend_next = sub_letter(pos_reg);
                        rem_next  = sum;
                    end
                end
            end
            OP_FLUSH: begin
                if (status.out_ok) begin
                    push            = pend_valid_reg;
                    out_last_next   = pend_valid_reg ? 1'b1 : out_last_reg;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
        if (push) begin
            out_valid_next = 1'b1;
            out_data_next  = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg        <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            rem_reg        <= rem_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending letter left while waiting for a number");

    a_main_reaches_place: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_MAIN) |-> (rem_reg >= pv_ext))
        else $error("main letter step with remainder below place value");

    a_last_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && out_last_next) |=> s_tready)
        else $error("sequencer not idle after last letter");

    a_pos_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("table position past the last letter");
`endif

endmodule

// ===== tb/roman_checker.sv =====
// ----------------------------------------------------------------------------
// roman_checker
// Watches both channels of the Roman numeral encoder, spells every accepted
// number into lower-case Roman letters and compares each output beat, letter
// and last flag, against the oldest letter still owed.
// ----------------------------------------------------------------------------
module roman_checker
    import rne_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] letter
    input  logic        m_tlast,   // last_letter
    output int          errors,
    output int          pending,
    output int          numbers_seen,
    output int          letters_seen,
    output int          longest
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LETTERS = 15;
    localparam int LAST_DIGIT  = 6;

    localparam logic [7:0] ROMAN_LETTER [7] = '{CHAR_M, CHAR_D, CHAR_C, CHAR_L,
                                                CHAR_X, CHAR_V, CHAR_I};
    localparam int STEP_DOWN [6] = '{2, 5, 2, 5, 2, 5};

    typedef struct packed {
        logic [7:0] letter;
        logic       last;
    } letter_beat_t;

    letter_beat_t owed_letters[$];

    task automatic spell_roman(input logic [11:0] value, output int count);
        logic [7:0] spelled[$];
        int rest;
        int place;
        int digit;
        int sub_digit;
        int unit;
        bit done;
        letter_beat_t beat;
        rest  = value;
        place = 1000;
        digit = 0;
        done  = 0;
        while (!done) begin
            while (rest >= place && spelled.size() < MAX_LETTERS) begin
                spelled = {spelled, ROMAN_LETTER[digit]};
                rest -= place;
            end
            if (rest == 0 || spelled.size() >= MAX_LETTERS || digit == LAST_DIGIT) begin
                done = 1;
            end else begin
                unit      = place / STEP_DOWN[digit];
                sub_digit = digit + 1;
                if (STEP_DOWN[digit] == 2) begin
                    sub_digit = digit + 2;
                    unit      = unit / STEP_DOWN[digit + 1];
                end
                if (rest + unit >= place) begin
                    spelled = {spelled, ROMAN_LETTER[sub_digit]};
                    rest += unit;
                end else begin
                    place = place / STEP_DOWN[digit];
                    digit++;
                end
            end
        end
        count = spelled.size();
        for (int k = 0; k < count; k++) begin
            beat.letter = spelled[k];
            beat.last   = (k == count - 1);
            owed_letters = {owed_letters, beat};
        end
    endtask

    always @(posedge aclk) begin
        letter_beat_t want;
        int n;
        if (!aresetn) begin
            owed_letters.delete();
            errors       <= 0;
            pending      <= 0;
            numbers_seen <= 0;
            letters_seen <= 0;
            longest      <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                spell_roman(s_tdata[11:0], n);
                numbers_seen <= numbers_seen + 1;
                if (n > longest) begin
                    longest <= n;
                end
            end
            if (m_tvalid && m_tready) begin
                if (owed_letters.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual letter %h last %b",
                             $time, m_tdata, m_tlast);
                    errors <= errors + 1;
                end else begin
                    want = owed_letters.pop_front();
                    if (want.letter !== m_tdata || want.last !== m_tlast) begin
                        $display("%0t: mismatch: expected letter %h last %b, actual %h last %b",
                                 $time, want.letter, want.last, m_tdata, m_tlast);
                        errors <= errors + 1;
                    end
                    letters_seen <= letters_seen + 1;
                end
            end
            pending <= owed_letters.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives numbers into the Roman numeral encoder: a directed set of edge values
// and subtractive cases, then random numbers in bursts, while the receiver
// stalls in changing patterns and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import rne_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM     = 140;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;

    localparam logic [11:0] DIRECTED_VALUES [25] = '{
        12'd0,    12'd1,    12'd4,    12'd5,    12'd9,
        12'd10,   12'd40,   12'd49,   12'd90,   12'd99,
        12'd400,  12'd444,  12'd500,  12'd900,  12'd999,
        12'd1000, 12'd1994, 12'd3888, 12'd3999, 12'd4000,
        12'd4094, 12'd4095, 12'd2048, 12'd1365, 12'd2730
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    logic hold_req = 1'b0;
    int   burst_left = 0;
    int   idle_cycles = 0;
    int   errors;
    int   pending;
    int   numbers_seen;
    int   letters_seen;
    int   longest;

    always #1 aclk = ~aclk;

    roman_numeral_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    roman_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .errors       (errors),
        .pending      (pending),
        .numbers_seen (numbers_seen),
        .letters_seen (letters_seen),
        .longest      (longest)
    );

    task automatic send_number(input logic [11:0] value);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic logic [11:0] random_number();
        case ($urandom_range(0, 9))
            0:       return 12'($urandom_range(0, 9));
            1, 2:    return 12'($urandom_range(0, 99));
            3, 4:    return 12'($urandom_range(0, 999));
            8:       return 12'($urandom_range(3000, 4095));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (DIRECTED_VALUES[i]) begin
            send_number(DIRECTED_VALUES[i]);
        end
        wait_drained();
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 40) begin
                hold_req <= 1'b1;
            end
            if (i == 90) begin
                wait_drained();
            end
            send_number(random_number());
        end
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Converted %0d numbers into %0d checked letters, longest numeral %0d letters,",
                 numbers_seen, letters_seen, longest);
        $display("under bursty input, varied output stalls and one long output hold-off.");
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 50;
        tick      = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req <= 1'b0;
            end else begin
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 8) < 5);
                endcase
                mode_left--;
                if (mode_left <= 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
